// ===== hw/rtl/ggd_pkg.sv =====
`default_nettype none
package ggd_pkg;

    localparam int CORDIC_ITERATIONS = 16;
    localparam int CW = 28;   // CORDIC x/y width, covers 25-bit offsets with gain
    localparam int ZW = 32;   // angle accumulator, 2^32 = two pi
    localparam int TIW = 5;   // arctangent table index width (24 entries)

    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_POSE  = 2'd1;
    localparam logic [1:0] OP_HALT  = 2'd2;

    localparam logic [2:0] CFG_GOAL_X    = 3'd0;
    localparam logic [2:0] CFG_GOAL_Y    = 3'd1;
    localparam logic [2:0] CFG_ANGLE_TOL = 3'd2;
    localparam logic [2:0] CFG_TURN_TOL  = 3'd3;
    localparam logic [2:0] CFG_RADIUS    = 3'd4;
    localparam logic [2:0] CFG_MIN_SPEED = 3'd5;
    localparam logic [2:0] CFG_MAX_SPEED = 3'd6;

    typedef enum logic [1:0] {
        RS_NOT_RUNNING = 2'd0,
        RS_STARTING    = 2'd1,
        RS_RUNNING     = 2'd2,
        RS_ACHIEVED    = 2'd3
    } t_run;

    typedef enum logic [1:0] {
        PH_STOP  = 2'd0,
        PH_TURN  = 2'd1,
        PH_POINT = 2'd2,
        PH_NONE  = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_PREP = 2'd1,
        S_CALC = 2'd2,
        S_EMIT = 2'd3
    } t_state;

    typedef struct packed {
        logic [1:0]         opcode;
        logic signed [23:0] pose_x;
        logic signed [23:0] pose_y;
        logic signed [15:0] pose_heading;
    } t_in_item;

    typedef struct packed {
        logic               cmd_valid;
        logic               drive_enable;
        logic signed [15:0] left_speed;
        logic signed [15:0] right_speed;
        logic [1:0]         goal_state;
        logic               goal_event;
        logic               last;
    } t_out_item;

    typedef struct packed {
        logic               valid;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic [ZW-1:0]      z;
    } t_cordic;

    function automatic logic [ZW-1:0] atan_entry(input logic [TIW-1:0] i);
        logic [ZW-1:0] v;
        unique case (i)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA;
            5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30;
            5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C;
            5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3;
            5'd23: v = 32'h00000051;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/ggd_cordic_cell.sv =====
`default_nettype none
// One vectoring micro-rotation; i_idx is this cell's place in the row.
module ggd_cordic_cell (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic [ggd_pkg::TIW-1:0]   i_idx,
    input  wire ggd_pkg::t_cordic          i_d,
    output ggd_pkg::t_cordic               o_d
);
    ggd_pkg::t_cordic r_d;
    ggd_pkg::t_cordic n_d;
    logic signed [ggd_pkg::CW-1:0] xs;
    logic signed [ggd_pkg::CW-1:0] ys;

    always_comb begin
        xs = i_d.x >>> i_idx;
        ys = i_d.y >>> i_idx;
        n_d.valid = i_d.valid;
        if (i_d.y > 0) begin
            n_d.x = i_d.x + ys;
            n_d.y = i_d.y - xs;
            n_d.z = i_d.z + ggd_pkg::atan_entry(i_idx);
        end else begin
            n_d.x = i_d.x - ys;
            n_d.y = i_d.y + xs;
            n_d.z = i_d.z - ggd_pkg::atan_entry(i_idx);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d.valid <= 1'b0;
        end else begin
            r_d.valid <= n_d.valid;
        end
        r_d.x <= n_d.x;
        r_d.y <= n_d.y;
        r_d.z <= n_d.z;
    end

    assign o_d = r_d;
endmodule
`default_nettype wire

// ===== hw/rtl/ggd_cordic_chain.sv =====
`default_nettype none
// Row of CORDIC cells, one iteration per cell, each cell registered.
module ggd_cordic_chain (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire ggd_pkg::t_cordic i_d,
    output ggd_pkg::t_cordic      o_d
);
    ggd_pkg::t_cordic w_link [ggd_pkg::CORDIC_ITERATIONS+1];

    assign w_link[0] = i_d;

    for (genvar g = 0; g < ggd_pkg::CORDIC_ITERATIONS; g++) begin : g_cell
        ggd_cordic_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_idx   (ggd_pkg::TIW'(g)),
            .i_d     (w_link[g]),
            .o_d     (w_link[g+1])
        );
    end

    assign o_d = w_link[ggd_pkg::CORDIC_ITERATIONS];
endmodule
`default_nettype wire

// ===== hw/rtl/goto_goal_drive_controller.sv =====
`default_nettype none
// Go-to-goal controller for a two-wheel rover. Start, halt and unknown opcodes are
// decided in the accept cycle; their results (zero to two) follow one per cycle
// while the output is not stalled. A pose update while listening passes through
// operand prep with the first cell, the rest of the cell row and the decision, then
// gives zero to three results, one per cycle while the output is not stalled. The
// CORDIC row length sets how long a pose update takes. One item is in flight at a
// time: o_in_stall is high from accept until the last result transfer. Config writes
// are always ready and must only be issued while the block is idle.
module goto_goal_drive_controller (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire ggd_pkg::t_in_item  i_in,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output ggd_pkg::t_out_item      o_out,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [2:0]         i_cfg_index,
    input  wire logic [23:0]        i_cfg_data
);
    // configuration registers
    logic signed [23:0] r_goal_x, r_goal_y;
    logic [14:0]        r_angle_tol, r_turn_tol, r_min, r_max;
    logic [22:0]        r_radius;

    // control state
    ggd_pkg::t_state r_state, n_state;
    ggd_pkg::t_run   r_run, n_run;
    ggd_pkg::t_phase r_phase, n_phase;
    logic            r_listen, n_listen;

    // per-item work registers
    logic signed [24:0] r_dx, r_dy;
    logic signed [15:0] r_head;
    logic               r_zero;
    logic [49:0]        r_dx2, r_dy2;
    logic [45:0]        r_r2;

    // result buffer
    ggd_pkg::t_out_item r_res [0:2];
    ggd_pkg::t_out_item n_res [0:2];
    logic [1:0]         r_cnt, n_cnt, r_idx, n_idx;

    ggd_pkg::t_cordic w_cin, w_cout;

    logic        w_acc;
    logic [15:0] w_atan;
    logic signed [16:0] w_err, w_tt, w_at;
    logic        w_inside;
    logic [14:0] w_s;
    logic signed [15:0] w_mn, w_v, w_vp;

    assign w_acc       = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != ggd_pkg::S_IDLE);
    assign o_out_valid = (r_state == ggd_pkg::S_EMIT);
    assign o_cfg_ready = 1'b1;

    always_comb begin
        o_out      = r_res[r_idx];
        o_out.last = (r_idx == r_cnt - 2'd1);
    end

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_goal_x    <= '0;
            r_goal_y    <= '0;
            r_angle_tol <= 15'd1024;
            r_turn_tol  <= 15'd1024;
            r_radius    <= 23'd10;
            r_min       <= '0;
            r_max       <= 15'h7FFF;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                ggd_pkg::CFG_GOAL_X:    r_goal_x    <= i_cfg_data;
                ggd_pkg::CFG_GOAL_Y:    r_goal_y    <= i_cfg_data;
                ggd_pkg::CFG_ANGLE_TOL: r_angle_tol <= i_cfg_data[14:0];
                ggd_pkg::CFG_TURN_TOL:  r_turn_tol  <= i_cfg_data[14:0];
                ggd_pkg::CFG_RADIUS:    r_radius    <= i_cfg_data[22:0];
                ggd_pkg::CFG_MIN_SPEED: r_min       <= i_cfg_data[14:0];
                ggd_pkg::CFG_MAX_SPEED: r_max       <= i_cfg_data[14:0];
                default: ;
            endcase
        end
    end

    // CORDIC feed: fold the left half plane onto the right, start angle at pi
    always_comb begin
        w_cin.valid = (r_state == ggd_pkg::S_PREP);
        if (r_dx < 0) begin
            w_cin.x = -ggd_pkg::CW'(r_dx);
            w_cin.y = -ggd_pkg::CW'(r_dy);
            w_cin.z = 32'h80000000;
        end else begin
            w_cin.x = ggd_pkg::CW'(r_dx);
            w_cin.y = ggd_pkg::CW'(r_dy);
            w_cin.z = '0;
        end
    end

    ggd_cordic_chain u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_d     (w_cin),
        .o_d     (w_cout)
    );

    // decision terms, valid when the row delivers
    always_comb begin
        logic [31:0] zr;
        zr       = w_cout.z + 32'h00008000;
        w_atan   = r_zero ? 16'd0 : zr[31:16];
        w_err    = 17'(signed'(w_atan - r_head));
        w_tt     = {2'b00, r_turn_tol};
        w_at     = {2'b00, r_angle_tol};
        w_inside = ({1'b0, r_dx2} + {1'b0, r_dy2}) <= {5'd0, r_r2};
        w_s      = (r_max > r_min) ? 15'((r_max - r_min) >> 2) : 15'd0;
        w_mn     = {1'b0, r_min};
        w_v      = w_mn + {1'b0, w_s};
        w_vp     = w_v + {1'b0, w_s};
    end

    function automatic ggd_pkg::t_out_item mk(input logic cv, input logic de,
                                              input logic signed [15:0] l,
                                              input logic signed [15:0] r,
                                              input ggd_pkg::t_run gs,
                                              input logic ev);
        ggd_pkg::t_out_item o;
        o.cmd_valid    = cv;
        o.drive_enable = de;
        o.left_speed   = l;
        o.right_speed  = r;
        o.goal_state   = gs;
        o.goal_event   = ev;
        o.last         = 1'b0;
        return o;
    endfunction

    // next state and result building
    always_comb begin
        logic done;
        n_state  = r_state;
        n_run    = r_run;
        n_phase  = r_phase;
        n_listen = r_listen;
        n_cnt    = r_cnt;
        n_idx    = r_idx;
        n_res    = r_res;
        done     = 1'b0;
        unique case (r_state)
            ggd_pkg::S_IDLE: begin
                if (w_acc) begin
                    n_cnt = '0;
                    n_idx = '0;
                    if (i_in.opcode == ggd_pkg::OP_POSE) begin
                        if (r_listen) n_state = ggd_pkg::S_PREP;
                    end else if (i_in.opcode == ggd_pkg::OP_START ||
                                 i_in.opcode == ggd_pkg::OP_HALT) begin
                        n_listen = 1'b0;
                        if (r_run == ggd_pkg::RS_RUNNING) begin
                            n_run   = ggd_pkg::RS_NOT_RUNNING;
                            n_phase = ggd_pkg::PH_NONE;
                            n_res[n_cnt] = mk(1'b1, 1'b0, '0, '0, n_run, 1'b1);
                            n_cnt = n_cnt + 2'd1;
                        end
                        if (i_in.opcode == ggd_pkg::OP_START) begin
                            n_run    = ggd_pkg::RS_STARTING;
                            n_listen = 1'b1;
                            n_res[n_cnt] = mk(1'b0, 1'b0, '0, '0, n_run, 1'b1);
                            n_cnt = n_cnt + 2'd1;
                        end
                    end
                    if (n_cnt != 2'd0) n_state = ggd_pkg::S_EMIT;
                end
            end
            ggd_pkg::S_PREP: begin
                n_state = ggd_pkg::S_CALC;
            end
            ggd_pkg::S_CALC: begin
                if (w_cout.valid) begin
                    if (n_run == ggd_pkg::RS_STARTING) begin
                        n_run   = ggd_pkg::RS_RUNNING;
                        n_phase = ggd_pkg::PH_STOP;
                    end
                    if (n_run == ggd_pkg::RS_RUNNING) begin
                        if (n_phase == ggd_pkg::PH_STOP) begin
                            n_res[n_cnt] = mk(1'b1, 1'b0, '0, '0, n_run, 1'b0);
                            n_cnt   = n_cnt + 2'd1;
                            n_phase = ggd_pkg::PH_TURN;
                        end
                        if (n_phase == ggd_pkg::PH_TURN) begin
                            if (w_err > w_tt) begin
                                n_res[n_cnt] = mk(1'b1, 1'b1, -w_mn, w_mn, n_run, 1'b0);
                                n_cnt = n_cnt + 2'd1;
                                done  = 1'b1;
                            end else if (w_err < -w_tt) begin
                                n_res[n_cnt] = mk(1'b1, 1'b1, w_mn, -w_mn, n_run, 1'b0);
                                n_cnt = n_cnt + 2'd1;
                                done  = 1'b1;
                            end else begin
                                n_res[n_cnt] = mk(1'b1, 1'b0, '0, '0, n_run, 1'b0);
                                n_cnt   = n_cnt + 2'd1;
                                n_phase = ggd_pkg::PH_POINT;
                            end
                        end
                        if (!done && n_phase == ggd_pkg::PH_POINT) begin
                            if (w_inside) begin
                                n_phase = ggd_pkg::PH_NONE;
                                n_run   = ggd_pkg::RS_ACHIEVED;
                                n_res[n_cnt] = mk(1'b1, 1'b0, '0, '0, n_run, 1'b1);
                            end else if (w_err > w_at) begin
                                n_res[n_cnt] = mk(1'b1, 1'b1, w_mn, w_vp, n_run, 1'b0);
                            end else if (w_err < -w_at) begin
                                n_res[n_cnt] = mk(1'b1, 1'b1, w_vp, w_mn, n_run, 1'b0);
                            end else begin
                                n_res[n_cnt] = mk(1'b1, 1'b1, w_v, w_v, n_run, 1'b0);
                            end
                            n_cnt = n_cnt + 2'd1;
                        end
                    end
                    n_state = (n_cnt != 2'd0) ? ggd_pkg::S_EMIT : ggd_pkg::S_IDLE;
                end
            end
            ggd_pkg::S_EMIT: begin
                if (!i_out_stall) begin
                    if (r_idx == r_cnt - 2'd1) n_state = ggd_pkg::S_IDLE;
                    else                       n_idx   = r_idx + 2'd1;
                end
            end
            default: n_state = ggd_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ggd_pkg::S_IDLE;
            r_run    <= ggd_pkg::RS_NOT_RUNNING;
            r_phase  <= ggd_pkg::PH_NONE;
            r_listen <= 1'b0;
            r_cnt    <= '0;
            r_idx    <= '0;
        end else begin
            r_state  <= n_state;
            r_run    <= n_run;
            r_phase  <= n_phase;
            r_listen <= n_listen;
            r_cnt    <= n_cnt;
            r_idx    <= n_idx;
        end
    end

    // payload: offsets at accept, squares during prep
    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        if (w_acc) begin
            r_dx   <= 25'(r_goal_x) - 25'(i_in.pose_x);
            r_dy   <= 25'(r_goal_y) - 25'(i_in.pose_y);
            r_head <= i_in.pose_heading;
            r_zero <= (r_goal_x == i_in.pose_x) && (r_goal_y == i_in.pose_y);
        end
        if (r_state == ggd_pkg::S_PREP) begin
            r_dx2 <= 50'(r_dx * r_dx);
            r_dy2 <= 50'(r_dy * r_dy);
            r_r2  <= r_radius * r_radius;
        end
    end

`ifndef ASSERT_OFF
    a_idle_no_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_stall |-> !o_out_valid) else $error("result shown while idle");
    a_emit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (r_cnt != 2'd0 && r_idx < r_cnt))
        else $error("result index outside buffer");
    a_chain_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cout.valid |-> (r_state == ggd_pkg::S_CALC))
        else $error("CORDIC result outside wait state");
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && o_out.last) |=> !o_out_valid)
        else $error("results continue after last transfer");
`endif
endmodule
`default_nettype wire

// ===== dv/goto_goal_drive_controller_tb.sv =====
`default_nettype none
module goto_goal_drive_controller_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ggd_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    t_in_item           i_in = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    t_out_item          o_out;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_index = '0;
    logic [23:0]        i_cfg_data = '0;

    always #1 i_clk = ~i_clk;

    goto_goal_drive_controller i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // ---------------------------------------------------------------
    // Controller shadow: registers and state mirrored in the bench
    // ---------------------------------------------------------------
    logic signed [23:0] sh_goal_x, sh_goal_y;
    logic [14:0]        sh_angle_tol, sh_turn_tol, sh_min_spd, sh_max_spd;
    logic [22:0]        sh_radius;
    t_run               sh_run;
    t_phase             sh_phase;
    logic               sh_listen;

    t_in_item  pending_items[$];
    t_out_item wheel_cmds_due[$];
    int        mismatches = 0;
    int        in_accepted = 0;
    bit        quiet = 1'b0;       // final stretch: no idling on either side
    bit        in_hold = 1'b1;     // holds the driver during config phases
    int        in_gap = 0, out_gap = 0, idle_cycles = 0;

    function automatic void shadow_reset();
        sh_goal_x = '0; sh_goal_y = '0;
        sh_angle_tol = 15'd1024; sh_turn_tol = 15'd1024;
        sh_radius = 23'd10; sh_min_spd = '0; sh_max_spd = 15'h7fff;
        sh_run = RS_NOT_RUNNING; sh_phase = PH_NONE; sh_listen = 1'b0;
    endfunction

    function automatic void shadow_config(logic [2:0] idx, logic [23:0] d);
        case (idx)
            CFG_GOAL_X:    sh_goal_x = d;
            CFG_GOAL_Y:    sh_goal_y = d;
            CFG_ANGLE_TOL: sh_angle_tol = d[14:0];
            CFG_TURN_TOL:  sh_turn_tol = d[14:0];
            CFG_RADIUS:    sh_radius = d[22:0];
            CFG_MIN_SPEED: sh_min_spd = d[14:0];
            CFG_MAX_SPEED: sh_max_spd = d[14:0];
            default: ;
        endcase
    endfunction

    function automatic void push_cmd(bit cv, bit de, longint l, longint r, bit ev);
        t_out_item o;
        o.cmd_valid = cv;
        o.drive_enable = de;
        o.left_speed = 16'(l);
        o.right_speed = 16'(r);
        o.goal_state = sh_run;
        o.goal_event = ev;
        o.last = 1'b0;
        wheel_cmds_due.push_back(o);
    endfunction

    // vectoring CORDIC, 2^32 = two pi, rounded to 16-bit binary angle
    function automatic logic signed [15:0] bearing(longint y, longint x);
        logic [31:0] acc;
        longint xs, ys;
        acc = '0;
        if (x == 0 && y == 0) return '0;
        if (x < 0) begin
            x = -x; y = -y; acc = 32'h8000_0000;
        end
        for (int i = 0; i < CORDIC_ITERATIONS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
                x += ys; y -= xs; acc += atan_entry(TIW'(i));
            end else begin
                x -= ys; y += xs; acc -= atan_entry(TIW'(i));
            end
        end
        acc += 32'h8000;
        return acc[31:16];
    endfunction

    function automatic void abandon_goal();
        sh_listen = 1'b0;
        if (sh_run == RS_RUNNING) begin
            sh_run = RS_NOT_RUNNING;
            sh_phase = PH_NONE;
            push_cmd(1, 0, 0, 0, 1);
        end
    endfunction

    function automatic void steer_on_pose(t_in_item it);
        longint dx, dy, err, mn, mx, s, v, r;
        logic signed [15:0] e16;
        dx = longint'(sh_goal_x) - longint'(it.pose_x);
        dy = longint'(sh_goal_y) - longint'(it.pose_y);
        e16 = bearing(dy, dx) - it.pose_heading;
        err = e16;
        mn = sh_min_spd;
        mx = sh_max_spd;
        if (sh_run == RS_STARTING) begin
            sh_run = RS_RUNNING; sh_phase = PH_STOP;
        end
        for (int g = 0; g < 3 && sh_run == RS_RUNNING; g++) begin
            case (sh_phase)
                PH_STOP: begin
                    push_cmd(1, 0, 0, 0, 0);
                    sh_phase = PH_TURN;
                end
                PH_TURN: begin
                    if (err > longint'(sh_turn_tol)) begin
                        push_cmd(1, 1, -mn, mn, 0); return;
                    end
                    if (err < -longint'(sh_turn_tol)) begin
                        push_cmd(1, 1, mn, -mn, 0); return;
                    end
                    push_cmd(1, 0, 0, 0, 0);
                    sh_phase = PH_POINT;
                end
                PH_POINT: begin
                    r = sh_radius;
                    if (dx * dx + dy * dy <= r * r) begin
                        sh_phase = PH_NONE;
                        sh_run = RS_ACHIEVED;
                        push_cmd(1, 0, 0, 0, 1);
                        return;
                    end
                    s = (mx > mn) ? (mx - mn) / 4 : 0;
                    v = mn + s;
                    if (err > longint'(sh_angle_tol)) push_cmd(1, 1, v - s, v + s, 0);
                    else if (err < -longint'(sh_angle_tol)) push_cmd(1, 1, v + s, v - s, 0);
                    else push_cmd(1, 1, v, v, 0);
                    return;
                end
                default: return;
            endcase
        end
    endfunction

    // expected results of one accepted transfer, last flag on the final one
    function automatic void predict_item(t_in_item it);
        int n0;
        n0 = wheel_cmds_due.size();
        case (it.opcode)
            OP_START: begin
                abandon_goal();
                sh_run = RS_STARTING;
                sh_listen = 1'b1;
                push_cmd(0, 0, 0, 0, 1);
            end
            OP_POSE: if (sh_listen) steer_on_pose(it);
            OP_HALT: abandon_goal();
            default: ;
        endcase
        if (wheel_cmds_due.size() > n0) wheel_cmds_due[$].last = 1'b1;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("ERROR t=%0t %s got %0d expected %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    // ---------------------------------------------------------------
    // Driver: input transfers from the pending queue, random gaps
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                predict_item(i_in);
                in_accepted++;
                void'(pending_items.pop_front());
            end
            if (i_in_valid && o_in_stall) begin
                // payload held while stalled
            end else if (in_gap > 0) begin
                in_gap--;
                i_in_valid <= 1'b0;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                in_gap = $urandom_range(0, 5);
                i_in_valid <= 1'b0;
            end else if (!in_hold && pending_items.size() > 0) begin
                i_in_valid <= 1'b1;
                i_in <= pending_items[0];
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // Monitor: compare result transfers, drive random output stall
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (wheel_cmds_due.size() == 0) begin
                    report_mismatch("unexpected result", 1, 0);
                end else begin
                    want = wheel_cmds_due.pop_front();
                    if (o_out.cmd_valid !== want.cmd_valid)
                        report_mismatch("cmd_valid", o_out.cmd_valid, want.cmd_valid);
                    if (o_out.drive_enable !== want.drive_enable)
                        report_mismatch("drive_enable", o_out.drive_enable, want.drive_enable);
                    if (o_out.left_speed !== want.left_speed)
                        report_mismatch("left_speed", o_out.left_speed, want.left_speed);
                    if (o_out.right_speed !== want.right_speed)
                        report_mismatch("right_speed", o_out.right_speed, want.right_speed);
                    if (o_out.goal_state !== want.goal_state)
                        report_mismatch("goal_state", o_out.goal_state, want.goal_state);
                    if (o_out.goal_event !== want.goal_event)
                        report_mismatch("goal_event", o_out.goal_event, want.goal_event);
                    if (o_out.last !== want.last)
                        report_mismatch("last", o_out.last, want.last);
                end
            end
            if (out_gap > 0) begin
                out_gap--;
                i_out_stall <= 1'b1;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                out_gap = $urandom_range(0, 5);
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // watchdog: cycles with no transfer on either channel
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || in_hold)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("goto_goal_drive_controller: mismatch");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    function automatic t_in_item make_item(logic [1:0] op, int px, int py, int hd);
        t_in_item it;
        it.opcode = op;
        it.pose_x = 24'(px);
        it.pose_y = 24'(py);
        it.pose_heading = 16'(hd);
        return it;
    endfunction

    function automatic t_in_item random_pose();
        t_in_item it;
        it.opcode = OP_POSE;
        if ($urandom_range(0, 3) == 0) begin
            it.pose_x = 24'($urandom);
            it.pose_y = 24'($urandom);
        end else begin
            // near the goal so arrival and fine steering both occur
            it.pose_x = sh_goal_x + 24'($signed($urandom_range(0, 80)) - 40);
            it.pose_y = sh_goal_y + 24'($signed($urandom_range(0, 80)) - 40);
        end
        it.pose_heading = 16'($urandom);
        return it;
    endfunction

    task automatic cfg_write(logic [2:0] idx, logic [23:0] d);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        shadow_config(idx, d);
        i_cfg_valid <= 1'b0;
    endtask

    // run queued items, then wait for drain plus the pose latency
    task automatic run_phase();
        in_hold = 1'b0;
        while (pending_items.size() > 0 || i_in_valid || wheel_cmds_due.size() > 0)
            @(posedge i_clk);
        in_hold = 1'b1;
        repeat (CORDIC_ITERATIONS + 10) @(posedge i_clk);
    endtask

    task automatic random_settings(bit extreme);
        cfg_write(CFG_GOAL_X, extreme ? 24'h7fffff : 24'($urandom));
        cfg_write(CFG_GOAL_Y, extreme ? 24'h800000 : 24'($urandom));
        cfg_write(CFG_ANGLE_TOL, extreme ? 24'h7fff : 24'($urandom_range(0, 4000)));
        cfg_write(CFG_TURN_TOL, extreme ? 24'h0 : 24'($urandom_range(0, 8000)));
        cfg_write(CFG_RADIUS, extreme ? 24'h7fffff : 24'($urandom_range(0, 60)));
        cfg_write(CFG_MIN_SPEED, extreme ? 24'h7fff : 24'($urandom_range(0, 32767)));
        cfg_write(CFG_MAX_SPEED, extreme ? 24'h0 : 24'($urandom_range(0, 32767)));
    endtask

    initial begin
        int r;
        shadow_reset();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: halt and pose while idle, start, phase walk, turns, arrival
        pending_items.push_back(make_item(OP_HALT, 0, 0, 0));
        pending_items.push_back(make_item(OP_POSE, 5, 5, 0));
        pending_items.push_back(make_item(2'd3, -1, -1, -1));
        pending_items.push_back(make_item(OP_START, 0, 0, 0));
        pending_items.push_back(make_item(OP_POSE, -8388608, -8388608, 32767));
        pending_items.push_back(make_item(OP_POSE, -8388608, -8388608, -32768));
        pending_items.push_back(make_item(OP_POSE, 8388607, 8388607, 0));
        pending_items.push_back(make_item(OP_START, 0, 0, 0));
        pending_items.push_back(make_item(OP_POSE, 0, 0, 0));
        pending_items.push_back(make_item(OP_POSE, 3, 3, 0));
        pending_items.push_back(make_item(OP_POSE, 0, 0, 0));
        pending_items.push_back(make_item(OP_POSE, 0, 0, 0));
        run_phase();

        // near-extreme settings: inverted speed limits, zero radius
        random_settings(1'b1);
        cfg_write(CFG_RADIUS, 24'd0);
        pending_items.push_back(make_item(OP_START, 0, 0, 0));
        pending_items.push_back(make_item(OP_POSE, 0, 0, 16384));
        pending_items.push_back(make_item(OP_POSE, -100, 100, -16384));
        pending_items.push_back(make_item(OP_POSE, 8388607, -8388608, 100));
        pending_items.push_back(make_item(OP_START, 1, 1, 1));
        pending_items.push_back(make_item(OP_POSE, 1, 1, 1));
        pending_items.push_back(make_item(OP_HALT, 0, 0, 0));
        pending_items.push_back(make_item(OP_POSE, 1, 1, 1));
        run_phase();

        // random: mostly start followed by pose streams, some halts and noise
        for (int ph = 0; ph < 5; ph++) begin
            random_settings(1'b0);
            if (ph == 4) quiet = 1'b1;
            for (int k = 0; k < 50; k++) begin
                r = $urandom_range(0, 19);
                if (r == 0) pending_items.push_back(make_item(OP_START, $urandom,
                    $urandom, $urandom));
                else if (r == 1) pending_items.push_back(make_item(OP_HALT, $urandom,
                    $urandom, $urandom));
                else if (r == 2) pending_items.push_back(make_item(2'd3, $urandom,
                    $urandom, $urandom));
                else pending_items.push_back(random_pose());
                if (k % 12 == 0) pending_items.push_back(make_item(OP_START, 0, 0, 0));
            end
            run_phase();
        end

        if (mismatches == 0) begin
            $display("goto_goal_drive_controller: match");
        end else begin
            $display("goto_goal_drive_controller: mismatch");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ===== files.f =====
hw/rtl/ggd_pkg.sv
hw/rtl/ggd_cordic_cell.sv
hw/rtl/ggd_cordic_chain.sv
hw/rtl/goto_goal_drive_controller.sv
dv/goto_goal_drive_controller_tb.sv
